// ----- src/srtdiv_pkg.sv -----
// shared constants and the stage type for the radix-2 srt divider
`timescale 1ns / 1ps

package srtdiv_pkg;

  localparam int unsigned Width = 8;
  localparam int unsigned LzW   = $clog2(Width);
  localparam int unsigned HiW   = Width + 2;
  localparam int unsigned Depth = Width + 2;

  // digit selection thresholds, plus and minus one half of the normalized range
  localparam logic signed [HiW-1:0] HalfPos = {3'b001, {(Width - 1){1'b0}}};
  localparam logic signed [HiW-1:0] HalfNeg = {3'b111, {(Width - 1){1'b0}}};

  typedef struct packed {
    logic [HiW-1:0]   hi;
    logic [Width-1:0] lo;
    logic [Width-1:0] q;
    logic [Width-1:0] d;
    logic [LzW-1:0]   lz;
    logic [Width-1:0] num;
    logic             dz;
  } stage_t;

endpackage

// ----- src/srtdiv_if.sv -----
// request and response channel interfaces of the srt divider
`timescale 1ns / 1ps

interface srtdiv_req_if;
  logic                          valid;
  logic                          ready;
  logic [srtdiv_pkg::Width-1:0]  dividend;
  logic [srtdiv_pkg::Width-1:0]  divisor;

  modport source (output valid, output dividend, output divisor, input ready);
  modport sink   (input valid, input dividend, input divisor, output ready);
endinterface

interface srtdiv_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [srtdiv_pkg::Width-1:0]  quotient;
  logic [srtdiv_pkg::Width-1:0]  remainder;
  logic                          divide_by_zero;

  modport source (output valid, output quotient, output remainder,
                  output divide_by_zero, input ready);
  modport sink   (input valid, input quotient, input remainder,
                  input divide_by_zero, output ready);
endinterface

// ----- src/srtdiv_norm.sv -----
// front stage: leading zero count and normalization of both operands
`timescale 1ns / 1ps

module srtdiv_norm (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          valid_i,
  output logic                          ready_o,
  input  logic [srtdiv_pkg::Width-1:0]  dividend_i,
  input  logic [srtdiv_pkg::Width-1:0]  divisor_i,
  output logic                          valid_o,
  input  logic                          ready_i,
  output srtdiv_pkg::stage_t            data_o
);

  logic [srtdiv_pkg::LzW-1:0]       lz;
  logic [2*srtdiv_pkg::Width-1:0]   xn;
  srtdiv_pkg::stage_t               st_d;
  srtdiv_pkg::stage_t               st_q;
  logic                             valid_q;

  always_comb begin
    lz = '0;
    for (int k = 0; k < srtdiv_pkg::Width; k++) begin
      if (divisor_i[k]) begin
        lz = srtdiv_pkg::LzW'(srtdiv_pkg::Width - 1 - k);
      end
    end
    xn = {{srtdiv_pkg::Width{1'b0}}, dividend_i} << lz;
    st_d.hi  = {2'b00, xn[2*srtdiv_pkg::Width-1:srtdiv_pkg::Width]};
    st_d.lo  = xn[srtdiv_pkg::Width-1:0];
    st_d.q   = '0;
    st_d.d   = divisor_i << lz;
    st_d.lz  = lz;
    st_d.num = dividend_i;
    st_d.dz  = (divisor_i == '0);
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      st_q <= st_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = st_q;

endmodule

// ----- src/srtdiv_cell.sv -----
// one srt step: double the partial remainder, pick a digit, add or subtract the divisor
`timescale 1ns / 1ps

module srtdiv_cell (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  output logic                ready_o,
  input  srtdiv_pkg::stage_t  data_i,
  output logic                valid_o,
  input  logic                ready_i,
  output srtdiv_pkg::stage_t  data_o
);

  logic [srtdiv_pkg::HiW-1:0]   t;
  logic [srtdiv_pkg::HiW-1:0]   dext;
  logic [srtdiv_pkg::Width-1:0] qs;
  srtdiv_pkg::stage_t           st_d;
  srtdiv_pkg::stage_t           st_q;
  logic                         valid_q;

  always_comb begin
    t    = {data_i.hi[srtdiv_pkg::HiW-2:0], data_i.lo[srtdiv_pkg::Width-1]};
    dext = {2'b00, data_i.d};
    qs   = {data_i.q[srtdiv_pkg::Width-2:0], 1'b0};
    st_d    = data_i;
    st_d.lo = {data_i.lo[srtdiv_pkg::Width-2:0], 1'b0};
    if ($signed(t) >= srtdiv_pkg::HalfPos) begin
      st_d.hi = t - dext;
      st_d.q  = qs | srtdiv_pkg::Width'(1);
    end else if ($signed(t) < srtdiv_pkg::HalfNeg) begin
      st_d.hi = t + dext;
      st_d.q  = qs - srtdiv_pkg::Width'(1);
    end else begin
      st_d.hi = t;
      st_d.q  = qs;
    end
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      st_q <= st_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = st_q;

endmodule

// ----- src/srtdiv_fix.sv -----
// final stage: negative remainder correction, denormalization and result register
`timescale 1ns / 1ps

module srtdiv_fix (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          valid_i,
  output logic                          ready_o,
  input  srtdiv_pkg::stage_t            data_i,
  output logic                          valid_o,
  input  logic                          ready_i,
  output logic [srtdiv_pkg::Width-1:0]  quotient_o,
  output logic [srtdiv_pkg::Width-1:0]  remainder_o,
  output logic                          divide_by_zero_o
);

  logic [srtdiv_pkg::HiW-1:0]   rfix;
  logic [srtdiv_pkg::Width-1:0] quot_d;
  logic [srtdiv_pkg::Width-1:0] rem_d;
  logic [srtdiv_pkg::Width-1:0] quot_q;
  logic [srtdiv_pkg::Width-1:0] rem_q;
  logic                         dz_q;
  logic                         valid_q;

  always_comb begin
    rfix   = data_i.hi;
    quot_d = data_i.q;
    if (data_i.hi[srtdiv_pkg::HiW-1]) begin
      rfix   = data_i.hi + {2'b00, data_i.d};
      quot_d = data_i.q - srtdiv_pkg::Width'(1);
    end
    rem_d = rfix[srtdiv_pkg::Width-1:0] >> data_i.lz;
    if (data_i.dz) begin
      quot_d = '1;
      rem_d  = data_i.num;
    end
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      quot_q <= quot_d;
      rem_q  <= rem_d;
      dz_q   <= data_i.dz;
    end
  end

  assign valid_o          = valid_q;
  assign quotient_o       = quot_q;
  assign remainder_o      = rem_q;
  assign divide_by_zero_o = dz_q;

endmodule

// ----- src/srt_radix2_divider_unit.sv -----
// top level of the pipelined radix-2 srt divider
`timescale 1ns / 1ps

// Unsigned divider, Width bits, giving quotient and remainder by radix-2 SRT
// with digits -1, 0, +1. A new division is accepted every cycle unless every
// stage is full and stalled; each result passes one normalization stage,
// one cell per quotient digit and one correction stage, so up to Width + 2
// divisions are in flight. Every stage has its own valid bit and a stage
// only holds when the stage after it is full and stalled, so bubbles close up
// and the request side keeps accepting while a result waits on the response
// side, until every stage is full. A zero divisor returns an all ones
// quotient, the dividend as the remainder and divide_by_zero set.

module srt_radix2_divider_unit (
  input  logic              clk_i,
  input  logic              rst_ni,
  srtdiv_req_if.sink        req_i,
  srtdiv_rsp_if.source      rsp_o
);

  srtdiv_pkg::stage_t stage_data [srtdiv_pkg::Width+1];
  logic               stage_valid [srtdiv_pkg::Width+1];
  logic               stage_ready [srtdiv_pkg::Width+1];

  srtdiv_norm u_norm (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (req_i.valid),
    .ready_o    (req_i.ready),
    .dividend_i (req_i.dividend),
    .divisor_i  (req_i.divisor),
    .valid_o    (stage_valid[0]),
    .ready_i    (stage_ready[0]),
    .data_o     (stage_data[0])
  );

  for (genvar g = 0; g < srtdiv_pkg::Width; g++) begin : g_cell
    srtdiv_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (stage_valid[g]),
      .ready_o (stage_ready[g]),
      .data_i  (stage_data[g]),
      .valid_o (stage_valid[g+1]),
      .ready_i (stage_ready[g+1]),
      .data_o  (stage_data[g+1])
    );
  end

  srtdiv_fix u_fix (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .valid_i          (stage_valid[srtdiv_pkg::Width]),
    .ready_o          (stage_ready[srtdiv_pkg::Width]),
    .data_i           (stage_data[srtdiv_pkg::Width]),
    .valid_o          (rsp_o.valid),
    .ready_i          (rsp_o.ready),
    .quotient_o       (rsp_o.quotient),
    .remainder_o      (rsp_o.remainder),
    .divide_by_zero_o (rsp_o.divide_by_zero)
  );

endmodule

// ----- src/srtdiv_chk.sv -----
// port level checker for the srt divider and its bind
`timescale 1ns / 1ps

module srtdiv_chk (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          req_valid_i,
  input logic                          req_ready_i,
  input logic                          rsp_valid_i,
  input logic                          rsp_ready_i,
  input logic [srtdiv_pkg::Width-1:0]  rsp_quotient_i,
  input logic [srtdiv_pkg::Width-1:0]  rsp_remainder_i,
  input logic                          rsp_dz_i
);

  localparam int unsigned CntW = $clog2(srtdiv_pkg::Depth + 1) + 1;

  logic [CntW-1:0] cnt_d;
  logic [CntW-1:0] cnt_q;
  logic            in_beat;
  logic            out_beat;

  assign in_beat  = req_valid_i && req_ready_i;
  assign out_beat = rsp_valid_i && rsp_ready_i;

  always_comb begin
    cnt_d = cnt_q;
    if (in_beat && !out_beat) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (!in_beat && out_beat) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  // no response while reset is held
  a_reset_quiet: assert property (@(posedge clk_i) !rst_ni |-> !rsp_valid_i)
    else $error("response valid during reset");

  // a stalled response beat holds its payload
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=>
      rsp_valid_i && $stable(rsp_quotient_i) && $stable(rsp_remainder_i) &&
      $stable(rsp_dz_i))
    else $error("response payload changed while stalled");

  // every response belongs to an accepted request
  a_no_orphan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i |-> cnt_q != '0)
    else $error("response without an outstanding request");

  // never more in flight than the pipeline can hold
  a_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(srtdiv_pkg::Depth))
    else $error("more divisions in flight than pipeline stages");

  // zero divisor gives an all ones quotient
  a_dz_quot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && rsp_dz_i |-> rsp_quotient_i == '1)
    else $error("divide by zero without all ones quotient");

endmodule

bind srt_radix2_divider_unit srtdiv_chk u_srtdiv_chk (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .req_valid_i     (req_i.valid),
  .req_ready_i     (req_i.ready),
  .rsp_valid_i     (rsp_o.valid),
  .rsp_ready_i     (rsp_o.ready),
  .rsp_quotient_i  (rsp_o.quotient),
  .rsp_remainder_i (rsp_o.remainder),
  .rsp_dz_i        (rsp_o.divide_by_zero)
);
